>>> hw/rtl/tmpg_pkg.sv
package tmpg_pkg;

  localparam int MAX_RINGS  = 1024;
  localparam int MAX_SLICES = 1024;
  localparam int PHASE_BITS = 16;

  localparam int CNT_W      = $clog2(MAX_RINGS + 1);
  localparam int SIN_W      = 16;
  localparam int FRAC_W     = 30;
  localparam int XSHIFT     = FRAC_W - (PHASE_BITS - 2);
  localparam int SIN_STAGES = 6;
  localparam int HORNER_N   = 4;
  localparam int WIDE_W     = 48;

  localparam logic [FRAC_W:0] ONE30 = (FRAC_W + 1)'(1) << FRAC_W;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  localparam logic [FRAC_W:0] SIN_COEF [0:HORNER_N] = '{
    31'd172270, 31'd5026996, 31'd85569306, 31'd693598675, 31'd1686629713
  };

  typedef enum logic [1:0] {
    REG_OUTER  = 2'd0,
    REG_INNER  = 2'd1,
    REG_RINGS  = 2'd2,
    REG_SLICES = 2'd3
  } cfg_reg_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c,
                                                 input logic [CNT_W-1:0] maxc);
    logic [CNT_W-1:0] res;
    if (c == '0) begin
      res = CNT_W'(1);
    end else if (c > maxc) begin
      res = maxc;
    end else begin
      res = c;
    end
    return res;
  endfunction

  function automatic logic signed [WIDE_W-1:0] rnd_away(input logic signed [WIDE_W-1:0] v,
                                                        input int n);
    logic [WIDE_W-1:0] mag;
    mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    mag = (mag + (WIDE_W'(1) << (n - 1))) >> n;
    return v[WIDE_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [WIDE_W-1:0] clamp_sym(input logic signed [WIDE_W-1:0] v,
                                                         input logic signed [WIDE_W-1:0] lim);
    logic signed [WIDE_W-1:0] res;
    if (v > lim) begin
      res = lim;
    end else if (v < -lim) begin
      res = -lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/tmpg_div.sv
module tmpg_div import tmpg_pkg::*; (
  input  logic                  clk,
  input  logic [CNT_W-1:0]      rem_in,
  input  logic [CNT_W-1:0]      count,
  output logic [PHASE_BITS-1:0] phase
);

  logic [CNT_W-1:0]      rem_r [PHASE_BITS];
  logic [PHASE_BITS-1:0] quo_r [PHASE_BITS];

  for (genvar k = 0; k < PHASE_BITS; k++) begin : g_step
    logic [CNT_W-1:0]      rem_prev;
    logic [PHASE_BITS-1:0] quo_prev;
    logic [CNT_W:0]        dbl;
    logic [CNT_W:0]        diff;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_prev = rem_in;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign quo_prev = quo_r[k-1];
    end

    assign dbl  = {rem_prev, 1'b0};
    assign ge   = dbl >= {1'b0, count};
    assign diff = dbl - {1'b0, count};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[CNT_W-1:0] : dbl[CNT_W-1:0];
      quo_r[k] <= {quo_prev[PHASE_BITS-2:0], ge};
    end
  end

  assign phase = quo_r[PHASE_BITS-1];

endmodule

>>> hw/rtl/tmpg_sine.sv
module tmpg_sine import tmpg_pkg::*; (
  input  logic                    clk,
  input  logic [PHASE_BITS-1:0]   phase,
  output logic signed [SIN_W-1:0] value
);

  logic [1:0]            quad;
  logic [FRAC_W:0]       xf;
  logic [FRAC_W:0]       xa;
  logic [2*FRAC_W+1:0]   sq;

  logic [FRAC_W:0]       x_r   [HORNER_N+1];
  logic [FRAC_W:0]       x2_r  [HORNER_N+1];
  logic                  neg_r [HORNER_N+1];
  logic [FRAC_W:0]       s_r   [HORNER_N];

  logic [2*FRAC_W+1:0]   yprod;
  logic [FRAC_W+2:0]     ysum;
  logic [FRAC_W+2-16:0]  q;
  logic [SIN_W-1:0]      qc;
  logic signed [SIN_W-1:0] value_r;

  assign quad = phase[PHASE_BITS-1:PHASE_BITS-2];
  assign xf   = {1'b0, phase[PHASE_BITS-3:0], {XSHIFT{1'b0}}};
  assign xa   = quad[0] ? ONE30 - xf : xf;
  assign sq   = (2*FRAC_W+2)'(xa) * (2*FRAC_W+2)'(xa);

  always_ff @(posedge clk) begin
    x_r[0]   <= xa;
    x2_r[0]  <= sq[2*FRAC_W:FRAC_W];
    neg_r[0] <= quad[1];
  end

  for (genvar h = 0; h < HORNER_N; h++) begin : g_horner
    logic [FRAC_W:0]     s_prev;
    logic [2*FRAC_W+1:0] prod;

    if (h == 0) begin : g_first
      assign s_prev = SIN_COEF[0];
    end else begin : g_next
      assign s_prev = s_r[h-1];
    end

    assign prod = (2*FRAC_W+2)'(x2_r[h]) * (2*FRAC_W+2)'(s_prev);

    always_ff @(posedge clk) begin
      s_r[h]     <= SIN_COEF[h+1] - prod[2*FRAC_W:FRAC_W];
      x_r[h+1]   <= x_r[h];
      x2_r[h+1]  <= x2_r[h];
      neg_r[h+1] <= neg_r[h];
    end
  end

  assign yprod = (2*FRAC_W+2)'(x_r[HORNER_N]) * (2*FRAC_W+2)'(s_r[HORNER_N-1]);
  assign ysum  = {1'b0, yprod[2*FRAC_W+1:FRAC_W]} + (FRAC_W+3)'(32768);
  assign q     = ysum[FRAC_W+2:16];
  assign qc    = (q > (FRAC_W-13)'(16384)) ? SIN_W'(16384) : q[SIN_W-1:0];

  always_ff @(posedge clk) begin
    value_r <= neg_r[HORNER_N] ? -$signed(qc) : $signed(qc);
  end

  assign value = value_r;

endmodule

>>> hw/rtl/torus_mesh_point_generator.sv
// Torus mesh point generator.
// Input channel: a grid point (in_ring_index, in_slice_index) is taken at every
// rising edge where start is high and busy is low. The block is fully pipelined,
// so busy stays low and a new word can enter in every cycle.
// Result channel: out_valid is high for exactly one cycle per accepted word and
// carries the vertex, the unit normal, the quad corner indices and the index
// error flag. The receiver cannot hold results off, and none is needed.
// Each word passes in order through the registered phase dividers, the sine
// polynomial pipelines, and the registers for the vertex products, rounding
// and the output.
// Throughput is one word per cycle.
// Configuration: cfg_valid/cfg_ready write one of four registers selected by
// cfg_index (outer radius, inner radius, ring count, slice count). cfg_ready is
// always high. Registers must be written only while no word is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// default radii and counts.
module torus_mesh_point_generator import tmpg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [10:0]        in_ring_index,
  input  logic [9:0]         in_slice_index,
  output logic               out_valid,
  output logic signed [16:0] out_vertex_x,
  output logic signed [16:0] out_vertex_y,
  output logic signed [15:0] out_vertex_z,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic               out_quad_valid,
  output logic [20:0]        out_corner_a,
  output logic [20:0]        out_corner_b,
  output logic [20:0]        out_corner_c,
  output logic [20:0]        out_corner_d,
  output logic               out_index_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  typedef struct packed {
    logic       err;
    logic       qv;
    logic [10:0] ring;
    logic [9:0]  slice;
  } side_t;

  localparam int SIDE_N = PHASE_BITS + SIN_STAGES;
  localparam int LAT    = SIDE_N + 3;

  logic [14:0]      outer_radius_r;
  logic [14:0]      inner_radius_r;
  logic [CNT_W-1:0] ring_count_r;
  logic [CNT_W-1:0] slice_count_r;
  logic [CNT_W-1:0] rc;
  logic [CNT_W-1:0] sc;

  logic             acc;
  side_t            side_nxt;
  side_t            side_r [SIDE_N];
  logic [LAT-1:0]   vld_r;
  logic [CNT_W-1:0] rem_u;
  logic [CNT_W-1:0] rem_v;
  logic [PHASE_BITS-1:0] ph_u;
  logic [PHASE_BITS-1:0] ph_v;
  logic signed [SIN_W-1:0] cu;
  logic signed [SIN_W-1:0] su;
  logic signed [SIN_W-1:0] cv;
  logic signed [SIN_W-1:0] sv;

  logic signed [30:0] r_ext;
  logic signed [30:0] m_t1_r;
  logic signed [30:0] z_t1_r;
  logic signed [30:0] ncu_t1_r;
  logic signed [30:0] nsu_t1_r;
  logic signed [SIN_W-1:0] cu_t1_r;
  logic signed [SIN_W-1:0] su_t1_r;
  logic signed [SIN_W-1:0] sv_t1_r;
  logic [20:0]        base_t1_r;
  logic [10:0]        jn_t1_r;
  side_t              side_t1_r;
  logic [10:0]        jinc;

  logic signed [46:0] px_t2_r;
  logic signed [46:0] py_t2_r;
  logic signed [15:0] vz_t2_r;
  logic signed [15:0] nx_t2_r;
  logic signed [15:0] ny_t2_r;
  logic signed [15:0] nz_t2_r;
  logic [20:0]        ca_t2_r;
  logic [20:0]        cb_t2_r;
  logic [20:0]        cc_t2_r;
  logic [20:0]        cd_t2_r;
  side_t              side_t2_r;
  logic signed [WIDE_W-1:0] nx_w;
  logic signed [WIDE_W-1:0] ny_w;
  logic signed [WIDE_W-1:0] nz_w;
  logic [20:0]        base_b;

  logic signed [16:0] vertex_x_r;
  logic signed [16:0] vertex_y_r;
  logic signed [15:0] vertex_z_r;
  logic signed [15:0] normal_x_r;
  logic signed [15:0] normal_y_r;
  logic signed [15:0] normal_z_r;
  logic               quad_valid_r;
  logic [20:0]        corner_a_r;
  logic [20:0]        corner_b_r;
  logic [20:0]        corner_c_r;
  logic [20:0]        corner_d_r;
  logic               index_error_r;
  logic signed [WIDE_W-1:0] vx_w;
  logic signed [WIDE_W-1:0] vy_w;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_radius_r <= 15'd512;
      inner_radius_r <= 15'd128;
      ring_count_r   <= CNT_W'(32);
      slice_count_r  <= CNT_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OUTER:  outer_radius_r <= cfg_data;
        REG_INNER:  inner_radius_r <= cfg_data;
        REG_RINGS:  ring_count_r   <= cfg_data[CNT_W-1:0];
        REG_SLICES: slice_count_r  <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  assign rc = eff_count(ring_count_r, CNT_W'(MAX_RINGS));
  assign sc = eff_count(slice_count_r, CNT_W'(MAX_SLICES));

  always_comb begin
    side_nxt.ring  = in_ring_index;
    side_nxt.slice = in_slice_index;
    side_nxt.err   = (in_ring_index > rc) || ({1'b0, in_slice_index} >= sc);
    side_nxt.qv    = in_ring_index < rc;
  end

  assign rem_u = (in_ring_index >= rc) ? '0 : in_ring_index;
  assign rem_v = ({1'b0, in_slice_index} >= sc) ? '0 : CNT_W'(in_slice_index);

  tmpg_div u_div_u (.clk(clk), .rem_in(rem_u), .count(rc), .phase(ph_u));
  tmpg_div u_div_v (.clk(clk), .rem_in(rem_v), .count(sc), .phase(ph_v));

  tmpg_sine u_sin_cu (.clk(clk), .phase(ph_u + QUARTER), .value(cu));
  tmpg_sine u_sin_su (.clk(clk), .phase(ph_u),           .value(su));
  tmpg_sine u_sin_cv (.clk(clk), .phase(ph_v + QUARTER), .value(cv));
  tmpg_sine u_sin_sv (.clk(clk), .phase(ph_v),           .value(sv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int k = 1; k < SIDE_N; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  assign r_ext = 31'($signed({1'b0, inner_radius_r}));
  assign jinc  = {1'b0, side_r[SIDE_N-1].slice} + 11'd1;

  always_ff @(posedge clk) begin
    m_t1_r    <= $signed({2'b00, outer_radius_r, 14'b0}) + r_ext * 31'(cv);
    z_t1_r    <= r_ext * 31'(sv);
    ncu_t1_r  <= 31'(cv) * 31'(cu);
    nsu_t1_r  <= 31'(cv) * 31'(su);
    cu_t1_r   <= cu;
    su_t1_r   <= su;
    sv_t1_r   <= sv;
    base_t1_r <= 21'(side_r[SIDE_N-1].ring) * 21'(sc);
    jn_t1_r   <= (jinc == sc) ? '0 : jinc;
    side_t1_r <= side_r[SIDE_N-1];
  end

  always_comb begin
    nx_w = clamp_sym(rnd_away(WIDE_W'(ncu_t1_r), 14), WIDE_W'(16384));
    ny_w = clamp_sym(rnd_away(WIDE_W'(nsu_t1_r), 14), WIDE_W'(16384));
    nz_w = WIDE_W'(sv_t1_r);
    if (m_t1_r == '0) begin
      nx_w = '0;
      ny_w = '0;
      nz_w = '0;
    end else if (m_t1_r < 0) begin
      nx_w = -nx_w;
      ny_w = -ny_w;
      nz_w = -nz_w;
    end
  end

  assign base_b = base_t1_r + 21'(sc);

  always_ff @(posedge clk) begin
    px_t2_r   <= 47'(m_t1_r) * 47'(cu_t1_r);
    py_t2_r   <= 47'(m_t1_r) * 47'(su_t1_r);
    vz_t2_r   <= 16'(clamp_sym(rnd_away(WIDE_W'(z_t1_r), 14), WIDE_W'(32767)));
    nx_t2_r   <= nx_w[15:0];
    ny_t2_r   <= ny_w[15:0];
    nz_t2_r   <= nz_w[15:0];
    ca_t2_r   <= base_t1_r + 21'(side_t1_r.slice);
    cb_t2_r   <= base_b + 21'(side_t1_r.slice);
    cc_t2_r   <= base_b + 21'(jn_t1_r);
    cd_t2_r   <= base_t1_r + 21'(jn_t1_r);
    side_t2_r <= side_t1_r;
  end

  assign vx_w = clamp_sym(rnd_away(WIDE_W'(px_t2_r), 28), WIDE_W'(65535));
  assign vy_w = clamp_sym(rnd_away(WIDE_W'(py_t2_r), 28), WIDE_W'(65535));

  always_ff @(posedge clk) begin
    index_error_r <= side_t2_r.err;
    if (side_t2_r.err) begin
      vertex_x_r   <= '0;
      vertex_y_r   <= '0;
      vertex_z_r   <= '0;
      normal_x_r   <= '0;
      normal_y_r   <= '0;
      normal_z_r   <= '0;
      quad_valid_r <= 1'b0;
      corner_a_r   <= '0;
      corner_b_r   <= '0;
      corner_c_r   <= '0;
      corner_d_r   <= '0;
    end else begin
      vertex_x_r   <= vx_w[16:0];
      vertex_y_r   <= vy_w[16:0];
      vertex_z_r   <= vz_t2_r;
      normal_x_r   <= nx_t2_r;
      normal_y_r   <= ny_t2_r;
      normal_z_r   <= nz_t2_r;
      quad_valid_r <= side_t2_r.qv;
      corner_a_r   <= side_t2_r.qv ? ca_t2_r : '0;
      corner_b_r   <= side_t2_r.qv ? cb_t2_r : '0;
      corner_c_r   <= side_t2_r.qv ? cc_t2_r : '0;
      corner_d_r   <= side_t2_r.qv ? cd_t2_r : '0;
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_vertex_x    = vertex_x_r;
  assign out_vertex_y    = vertex_y_r;
  assign out_vertex_z    = vertex_z_r;
  assign out_normal_x    = normal_x_r;
  assign out_normal_y    = normal_y_r;
  assign out_normal_z    = normal_z_r;
  assign out_quad_valid  = quad_valid_r;
  assign out_corner_a    = corner_a_r;
  assign out_corner_b    = corner_b_r;
  assign out_corner_c    = corner_c_r;
  assign out_corner_d    = corner_d_r;
  assign out_index_error = index_error_r;

  a_err_no_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_index_error && out_quad_valid))
    else $error("quad marked valid on an index error");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_normal_z <= 16'sd16384) && (out_normal_z >= -16'sd16384))
    else $error("normal z out of unit range");

  a_err_zero_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_error) |-> (out_vertex_x == '0) && (out_normal_x == '0))
    else $error("error word carries nonzero payload");

  a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_quad_valid) |-> (out_corner_b != out_corner_a) || (out_corner_a == '0))
    else $error("corner b equals corner a");

endmodule
